// File: rtl/core/bri_pkg.sv
// ----------------------------------------------------------------------------
// bri_pkg
// shared widths, types and state codes of the bounded random integer filter
// ----------------------------------------------------------------------------
`default_nettype none

package bri_pkg;

    localparam int RAND_W  = 64;   // random word lane width
    localparam int BOUND_W = 63;   // bound and result value width
    localparam int TDATA_W = 64;   // byte-padded stream data width
    localparam int HALF_W  = 32;   // partial product operand width
    localparam int PROD_W  = 127;  // full product width (RAND_W + BOUND_W)

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_thr_state;

    typedef struct packed {
        logic               busy;
        logic [BOUND_W-1:0] thresh;
    } t_thr_stat;

endpackage

`default_nettype wire

// File: rtl/core/bri_mul.sv
// ----------------------------------------------------------------------------
// bri_mul
// three-stage 64 x 63 multiplier built from four partial products of 32 x 32 and 32 x 31 bits
// ----------------------------------------------------------------------------
`default_nettype none

module bri_mul (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [bri_pkg::RAND_W-1:0]   i_a,
    input  wire logic [bri_pkg::BOUND_W-1:0]  i_b,
    output logic      [bri_pkg::PROD_W-1:0]   o_prod
);

    localparam int H = bri_pkg::HALF_W;

    logic [2*H-1:0]   w_p00_n;
    logic [2*H-2:0]   w_p01_n;
    logic [2*H-1:0]   w_p10_n;
    logic [2*H-2:0]   w_p11_n;

    logic [2*H-1:0]   r_p00;
    logic [2*H-2:0]   r_p01;
    logic [2*H-1:0]   r_p10;
    logic [2*H-2:0]   r_p11;

    logic [2*H-1:0]   r_lo2;
    logic [2*H:0]     r_mid2;
    logic [2*H-2:0]   r_hi2;

    logic [2*H:0]     n_mid;
    logic [4*H-1:0]   n_sum;
    logic [bri_pkg::PROD_W-1:0] r_prod;

    // stage 1: partial products
    assign w_p00_n = i_a[H-1:0]   * i_b[H-1:0];
    assign w_p01_n = i_a[H-1:0]   * i_b[2*H-2:H];
    assign w_p10_n = i_a[2*H-1:H] * i_b[H-1:0];
    assign w_p11_n = i_a[2*H-1:H] * i_b[2*H-2:H];

    // stage 2: cross terms
    assign n_mid = {2'b00, r_p01} + {1'b0, r_p10};

    // stage 3: final sum
    assign n_sum = {1'b0, r_hi2, {(2*H){1'b0}}}
                 + {{(H-1){1'b0}}, r_mid2, {H{1'b0}}}
                 + {{(2*H){1'b0}}, r_lo2};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= w_p00_n;
            r_p01  <= w_p01_n;
            r_p10  <= w_p10_n;
            r_p11  <= w_p11_n;
            r_lo2  <= r_p00;
            r_mid2 <= n_mid;
            r_hi2  <= r_p11;
            r_prod <= n_sum[bri_pkg::PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/core/bri_thr.sv
// ----------------------------------------------------------------------------
// bri_thr
// serial remainder unit: rejection threshold 2^WORD_BITS mod bound, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bri_thr #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [bri_pkg::BOUND_W-1:0]  i_start_bound,
    input  wire logic [bri_pkg::BOUND_W-1:0]  i_bound,
    output bri_pkg::t_thr_stat                o_stat
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    bri_pkg::t_thr_state          r_state, n_state;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [bri_pkg::BOUND_W-1:0]  r_rem, n_rem;
    logic [bri_pkg::BOUND_W:0]    w_dbl;
    logic [bri_pkg::BOUND_W:0]    w_diff;

    assign w_dbl  = {r_rem, 1'b0};
    assign w_diff = w_dbl - {1'b0, i_bound};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        if (i_start) begin
            n_state = bri_pkg::ST_RUN;
            n_cnt   = CNT_W'(WORD_BITS);
            // 1 mod bound; zero for bound of zero or one
            n_rem   = (i_start_bound > bri_pkg::BOUND_W'(1))
                    ? bri_pkg::BOUND_W'(1) : '0;
        end else begin
            unique case (r_state)
                bri_pkg::ST_IDLE: begin
                end
                bri_pkg::ST_RUN: begin
                    n_rem = (w_dbl >= {1'b0, i_bound})
                          ? w_diff[bri_pkg::BOUND_W-1:0]
                          : w_dbl[bri_pkg::BOUND_W-1:0];
                    n_cnt = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = bri_pkg::ST_IDLE;
                    end
                end
                default: begin
                    n_state = bri_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bri_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
        end
    end

    assign o_stat.busy   = (r_state == bri_pkg::ST_RUN);
    assign o_stat.thresh = r_rem;

endmodule

`default_nettype wire

// File: rtl/core/bounded_random_integer_filter.sv
// an accepted item passes the multiplier stages and the output register
// throughput: one item per cycle unless stalled; a rejected item leaves a
// gap in the output; a bound write starts the serial remainder unit, and
// s_axis_tready is low while it runs or while a result waits for m_axis_tready
// reset: bound 1, threshold 0, pipeline and output register empty
// ----------------------------------------------------------------------------
// bounded_random_integer_filter
// multiplies each random word by the bound and keeps the high part when the
// low part clears the rejection threshold
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_random_integer_filter #(
    parameter int WORD_BITS = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bri_pkg::BOUND_W-1:0]   i_cfg_wdata,    // bound
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [bri_pkg::TDATA_W-1:0]   s_axis_tdata,   // [63:0] random_word
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [bri_pkg::TDATA_W-1:0]   m_axis_tdata    // [62:0] value, [63] zero
);

    localparam logic [bri_pkg::RAND_W-1:0] WORD_MASK =
        (WORD_BITS >= bri_pkg::RAND_W) ? {bri_pkg::RAND_W{1'b1}}
                                       : ((64'd1 << WORD_BITS) - 64'd1);

    logic [bri_pkg::BOUND_W-1:0]  r_bound;
    bri_pkg::t_thr_stat           w_stat;

    logic                         w_en;
    logic                         w_accept;
    logic                         r_v1, r_v2, r_v3;
    logic [bri_pkg::PROD_W-1:0]   w_prod;
    logic [bri_pkg::RAND_W-1:0]   w_low;
    logic [bri_pkg::BOUND_W-1:0]  w_high;
    logic                         w_keep;

    logic                         r_out_vld;
    logic [bri_pkg::BOUND_W-1:0]  r_out_value;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en && !w_stat.busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound <= bri_pkg::BOUND_W'(1);
        end else if (i_cfg_we) begin
            r_bound <= i_cfg_wdata;
        end
    end

    bri_thr #(
        .WORD_BITS (WORD_BITS)
    ) u_thr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_cfg_we),
        .i_start_bound (i_cfg_wdata),
        .i_bound       (r_bound),
        .o_stat        (w_stat)
    );

    bri_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (s_axis_tdata & WORD_MASK),
        .i_b    (r_bound),
        .o_prod (w_prod)
    );

    assign w_low  = w_prod[bri_pkg::RAND_W-1:0] & WORD_MASK;
    assign w_high = w_prod[WORD_BITS +: bri_pkg::BOUND_W];
    assign w_keep = (r_bound != '0) && (w_low >= {1'b0, w_stat.thresh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_v1      <= w_accept;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_out_vld <= r_v3 && w_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_value <= w_high;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_value};

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> ($stable(r_v3) && $stable(r_v1)))
        else $error("pipeline moved while output stalled");

    a_busy_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(w_stat.busy) |-> $past(i_cfg_we))
        else $error("threshold unit started without a bound write");

    a_thresh_below_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_stat.busy && (r_bound != '0)) |-> (w_stat.thresh < r_bound))
        else $error("threshold not below bound");

endmodule

`default_nettype wire

// File: tb/bri_value_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bri_value_checker
// watches the bound writes and both streams, keeps its own copy of the bound
// and rejection threshold, predicts which words pass and the value each one
// yields, and compares every result item with the oldest prediction
// ----------------------------------------------------------------------------

module bri_value_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bri_pkg::BOUND_W-1:0]  i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  logic [bri_pkg::TDATA_W-1:0]  s_axis_tdata,     // [63:0] random_word
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  logic [bri_pkg::TDATA_W-1:0]  m_axis_tdata,     // [62:0] value, [63] zero
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_words,
    output int                           o_values,
    output int                           o_dropped
);

    logic [bri_pkg::BOUND_W-1:0] bound_q;
    logic [bri_pkg::RAND_W-1:0]  thresh_q;
    logic [bri_pkg::BOUND_W-1:0] value_q[$];
    logic [bri_pkg::BOUND_W-1:0] next_value;
    logic [bri_pkg::BOUND_W-1:0] want_value;

    // 2^64 mod bound, zero for a bound of zero
    function automatic logic [bri_pkg::RAND_W-1:0] threshold_of(
        input logic [bri_pkg::BOUND_W-1:0] b
    );
        logic [bri_pkg::RAND_W:0] span;
        logic [bri_pkg::RAND_W:0] rem;
        span = '0;
        span[bri_pkg::RAND_W] = 1'b1;
        if (b == '0) begin
            return '0;
        end
        rem = span % {2'b00, b};
        return rem[bri_pkg::RAND_W-1:0];
    endfunction

    function automatic logic keep_word(input logic [bri_pkg::RAND_W-1:0] w,
                                       output logic [bri_pkg::BOUND_W-1:0] v);
        logic [bri_pkg::PROD_W:0] prod;
        prod = {{(bri_pkg::PROD_W+1-bri_pkg::RAND_W){1'b0}}, w}
             * {{(bri_pkg::PROD_W+1-bri_pkg::BOUND_W){1'b0}}, bound_q};
        v = prod[bri_pkg::PROD_W-1:bri_pkg::RAND_W];
        if (bound_q == '0) begin
            return 1'b0;
        end
        return prod[bri_pkg::RAND_W-1:0] >= thresh_q;
    endfunction

    task automatic note_miss(input string what, input logic [bri_pkg::TDATA_W-1:0] want,
                             input logic [bri_pkg::TDATA_W-1:0] got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s: expected %h actual %h", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bound_q  = bri_pkg::BOUND_W'(1);
            thresh_q = '0;
            value_q.delete();
        end else begin
            if (i_cfg_we) begin
                bound_q  = i_cfg_wdata;
                thresh_q = threshold_of(i_cfg_wdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                o_words++;
                if (keep_word(s_axis_tdata, next_value)) begin
                    value_q.push_back(next_value);
                end else begin
                    o_dropped++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                o_values++;
                if (value_q.size() == 0) begin
                    note_miss("value with none pending", '0, m_axis_tdata);
                end else begin
                    want_value = value_q.pop_front();
                    if (m_axis_tdata !== {1'b0, want_value}) begin
                        note_miss("value mismatch", {1'b0, want_value}, m_axis_tdata);
                    end
                end
            end
        end
        o_pending = value_q.size();
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives random words through the bounded random integer filter under many
// bound settings with random stalls on both streams, and reports the verdict
// ----------------------------------------------------------------------------

module tb;

    localparam int STALL_PCT     = 9;
    localparam int WATCHDOG      = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 70;
    localparam int CALM_PHASE    = 3;
    localparam int HOLD_PHASE    = 5;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic [bri_pkg::BOUND_W-1:0] i_cfg_wdata   = '0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [bri_pkg::TDATA_W-1:0] s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [bri_pkg::TDATA_W-1:0] m_axis_tdata;

    bit calm = 1'b0;
    int fail_count;
    int pending_values;
    int words_seen;
    int values_seen;
    int words_dropped;
    int bound_writes = 0;
    int quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    bounded_random_integer_filter #(
        .WORD_BITS(64)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bri_value_checker value_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_values),
        .o_words       (words_seen),
        .o_values      (values_seen),
        .o_dropped     (words_dropped)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("timeout: no item moved for %0d cycles", WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [bri_pkg::RAND_W-1:0] w);
        while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain_values();
        s_axis_tvalid <= 1'b0;
        while (pending_values != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_bound(input logic [bri_pkg::BOUND_W-1:0] b);
        drain_values();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        bound_writes++;
    endtask

    function automatic logic [bri_pkg::RAND_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return {$urandom, $urandom} >> $urandom_range(1, 63);
            3:       return ~({$urandom, $urandom} >> $urandom_range(1, 63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [bri_pkg::BOUND_W-1:0] pick_bound();
        logic [bri_pkg::BOUND_W-1:0] one;
        one = bri_pkg::BOUND_W'(1);
        case ($urandom_range(0, 6))
            0:       return bri_pkg::BOUND_W'($urandom_range(1, 16));
            1:       return one << $urandom_range(0, 62);
            2:       return {bri_pkg::BOUND_W{1'b1}}
                          - bri_pkg::BOUND_W'($urandom_range(0, 15));
            3:       return {1'b1, 30'($urandom), $urandom};
            4:       return 63'h5555555555555556
                          - bri_pkg::BOUND_W'($urandom_range(0, 3));
            5:       return {31'b0, $urandom} | one;
            default: return bri_pkg::BOUND_W'({$urandom, $urandom}) | one;
        endcase
    endfunction

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset bound of one, every word passes with value zero
        send_word('0);
        send_word('1);
        send_word(64'h1);

        write_bound({bri_pkg::BOUND_W{1'b1}});
        send_word('0);
        send_word(64'h1);
        send_word(64'hFFFF_FFFF_FFFF_FFFE);
        send_word(64'h7FFF_FFFF_FFFF_FFFF);
        send_word(64'h8000_0000_0000_0000);

        // bound of zero drops everything
        write_bound('0);
        send_word('0);
        send_word('1);
        send_word({$urandom, $urandom});

        write_bound(63'd3);
        send_word('0);
        send_word(64'hAAAA_AAAA_AAAA_AAAB);
        send_word('1);

        write_bound(63'h5555555555555556);
        send_word({$urandom, $urandom});
        send_word({$urandom, $urandom});
        send_word('1);

        write_bound(63'h4000000000000000);
        send_word('1);
        send_word('0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_bound(pick_bound());
            calm = (ph == CALM_PHASE);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (ph == HOLD_PHASE && k == PHASE_WORDS / 2) begin
                    drain_values();
                end
                send_word(pick_word());
            end
        end
        calm = 1'b0;

        drain_values();
        $display("summary: %0d words under %0d bound writes, %0d values checked, %0d dropped",
                 words_seen, bound_writes, values_seen, words_dropped);
        if (fail_count == 0 && pending_values == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
